FILE: rtl/core/gtg_pkg.sv
// shared types, constants and functions of the go-to-goal controller
package gtg_pkg;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps   = 25;

  localparam int AngPi    = 205887;
  localparam int AngTwoPi = 411775;
  localparam int ErrMax   = 25736;

  typedef enum logic [1:0] {
    OP_ROTATE = 2'd0,
    OP_MOVE   = 2'd1,
    OP_DRIVE  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    REG_GAIN_LIN  = 3'd0,
    REG_GAIN_ANG  = 3'd1,
    REG_LIMIT_LIN = 3'd2,
    REG_LIMIT_ANG = 3'd3,
    REG_TOL_DIST  = 3'd4,
    REG_TOL_HEAD  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic signed [15:0] pose_heading;
    logic signed [23:0] goal_x;
    logic signed [23:0] goal_y;
    logic               obstacle;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               reached;
    logic               halted;
    logic [23:0]        distance_left;
    logic signed [15:0] heading_error;
  } out_word_t;

  typedef struct packed {
    logic [15:0] gain_linear;
    logic [15:0] gain_angular;
    logic [22:0] limit_linear;
    logic [14:0] limit_angular;
    logic [22:0] tol_distance;
    logic [14:0] tol_heading;
  } cfg_t;

  function automatic logic [16:0] atan_entry(input int i);
    logic [16:0] r;
    case (i)
      0: r = 17'd51472;  1: r = 17'd30386;  2: r = 17'd16055;  3: r = 17'd8150;
      4: r = 17'd4091;   5: r = 17'd2047;   6: r = 17'd1024;   7: r = 17'd512;
      8: r = 17'd256;    9: r = 17'd128;   10: r = 17'd64;    11: r = 17'd32;
      12: r = 17'd16;   13: r = 17'd8;     14: r = 17'd4;     15: r = 17'd2;
      16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/gtg_stream_if.sv
// valid/ready channel with a generic payload
interface gtg_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/gtg_cfg_if.sv
// configuration write channel
interface gtg_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/gtg_geom_pipe.sv
// pipelined distance (bitwise square root) and cordic angle datapath
module gtg_geom_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      in_valid_i,
  input  gtg_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  output gtg_pkg::in_word_t         out_word_o,
  output logic [24:0]               dist_o,
  output logic signed [20:0]        angle_o
);
  import gtg_pkg::*;

  localparam int Depth = SqrtSteps + 2;

  typedef struct packed {
    in_word_t           w;
    logic [49:0]        rem;
    logic [49:0]        sq;
    logic [24:0]        root;
    logic signed [27:0] cx;
    logic signed [27:0] cy;
    logic signed [20:0] cz;
  } stage_t;

  logic   [Depth-1:0] vld_q;
  stage_t             st_q [Depth];
  stage_t             st_d [Depth];

  always_comb begin
    logic signed [24:0] dx, dy;
    logic [24:0]        ax, ay;
    logic [49:0]        trial;
    logic signed [27:0] xs, ys;
    dx = 25'(in_word_i.goal_x) - 25'(in_word_i.pose_x);
    dy = 25'(in_word_i.goal_y) - 25'(in_word_i.pose_y);
    ax = dx[24] ? 25'(-dx) : dx;
    ay = dy[24] ? 25'(-dy) : dy;
    st_d[0].w    = in_word_i;
    st_d[0].rem  = 50'(ax * ax);
    st_d[0].sq   = 50'(ay * ay);
    st_d[0].root = '0;
    st_d[0].cx   = 28'(dx);
    st_d[0].cy   = 28'(dy);
    st_d[0].cz   = '0;
    // stage 1: sum of squares, quadrant fold
    st_d[1] = st_q[0];
    st_d[1].rem = st_q[0].rem + st_q[0].sq;
    st_d[1].sq  = '0;
    if (st_q[0].cx < 0) begin
      st_d[1].cz = (st_q[0].cy >= 0) ? 21'(AngPi) : -21'(AngPi);
      st_d[1].cx = -st_q[0].cx;
      st_d[1].cy = -st_q[0].cy;
    end
    for (int s = 0; s < SqrtSteps; s++) begin
      st_d[s+2] = st_q[s+1];
      trial = 50'({st_q[s+1].root, 2'b01}) << (2 * (SqrtSteps - 1 - s));
      if (st_q[s+1].rem >= trial) begin
        st_d[s+2].rem  = st_q[s+1].rem - trial;
        st_d[s+2].root = {st_q[s+1].root[23:0], 1'b1};
      end else begin
        st_d[s+2].root = {st_q[s+1].root[23:0], 1'b0};
      end
      if (s < CordicSteps) begin
        xs = st_q[s+1].cx >>> s;
        ys = st_q[s+1].cy >>> s;
        if (st_q[s+1].cx == 0 && st_q[s+1].cy == 0) begin
          st_d[s+2].cz = st_q[s+1].cz;
        end else if (st_q[s+1].cy >= 0) begin
          st_d[s+2].cx = st_q[s+1].cx + ys;
          st_d[s+2].cy = st_q[s+1].cy - xs;
          st_d[s+2].cz = st_q[s+1].cz + 21'(atan_entry(s));
        end else begin
          st_d[s+2].cx = st_q[s+1].cx - ys;
          st_d[s+2].cy = st_q[s+1].cy + xs;
          st_d[s+2].cz = st_q[s+1].cz - 21'(atan_entry(s));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < Depth; s++) st_q[s] <= st_d[s];
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign out_word_o  = st_q[Depth-1].w;
  assign dist_o      = st_q[Depth-1].root;
  assign angle_o     = st_q[Depth-1].cz;
endmodule

FILE: rtl/core/go_to_goal_p_controller.sv
// go-to-goal proportional controller top level
// Each word gives one result. The datapath is a 30-stage pipeline (bitwise square root
// and cordic, one bit or rotation a stage, then error, gain and clamp stages), so a new
// word is taken every cycle while the output is not stalled; an output
// stall holds the whole pipeline. Zero pose-to-goal offset gives angle zero.
module go_to_goal_p_controller (
  input  logic clk_i,
  input  logic rst_ni,
  gtg_cfg_if.sink cfg,
  gtg_stream_if.sink in_s,
  gtg_stream_if.source out_s
);
  import gtg_pkg::*;

  cfg_t cfg_q;
  logic adv;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{16'd1229, 16'd819, 23'd6554, 15'd2458, 23'd6554, 15'd410};
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GAIN_LIN:  cfg_q.gain_linear   <= cfg.wdata[15:0];
        REG_GAIN_ANG:  cfg_q.gain_angular  <= cfg.wdata[15:0];
        REG_LIMIT_LIN: cfg_q.limit_linear  <= cfg.wdata[22:0];
        REG_LIMIT_ANG: cfg_q.limit_angular <= cfg.wdata[14:0];
        REG_TOL_DIST:  cfg_q.tol_distance  <= cfg.wdata[22:0];
        REG_TOL_HEAD:  cfg_q.tol_heading   <= cfg.wdata[14:0];
        default: ;
      endcase
    end
  end

  logic               g_vld;
  in_word_t           g_w;
  logic [24:0]        g_dist;
  logic signed [20:0] g_ang;

  logic     t_vld_q [3];
  assign adv      = !out_s.valid || out_s.ready;
  assign in_s.ready = adv;

  gtg_geom_pipe u_geom (
    .clk_i, .rst_ni, .adv_i(adv), .in_valid_i(in_s.valid), .in_word_i(in_s.data),
    .out_valid_o(g_vld), .out_word_o(g_w), .dist_o(g_dist), .angle_o(g_ang)
  );

  // stage a: wrap, round and clamp heading error
  in_word_t           a_w_q;
  logic [24:0]        a_dist_q;
  logic signed [15:0] a_herr_q;
  logic signed [21:0] err, erw;
  logic signed [19:0] hr;
  always_comb begin
    err = 22'(g_ang) - 22'(g_w.pose_heading) * 22'sd8;
    erw = err;
    if (err < 0) begin
      if (err <= -22'(AngPi)) erw = err + 22'(AngTwoPi);
    end else if (err >= 22'(AngPi)) begin
      erw = err - 22'(AngTwoPi);
    end
    hr = 20'((erw + 22'sd4) >>> 3);
  end

  // stage b: products
  in_word_t           b_w_q;
  logic [24:0]        b_dist_q;
  logic signed [15:0] b_herr_q;
  logic [40:0]        b_lin_q;
  logic signed [32:0] b_ang_q;

  // stage c: clamp and select
  out_word_t          c_q;
  logic signed [41:0] lin_r;
  logic signed [33:0] ang_r;
  logic signed [33:0] lim_a;
  logic               rch;
  logic [15:0]        aerr;
  logic               use_l, use_a;
  out_word_t          c_d;
  always_comb begin
    lin_r = (42'(b_lin_q) + 42'sd2048) >>> 12;
    ang_r = (34'(b_ang_q) + 34'sd2048) >>> 12;
    lim_a = 34'(cfg_q.limit_angular);
    if (lin_r > 42'(cfg_q.limit_linear)) lin_r = 42'(cfg_q.limit_linear);
    if (ang_r > lim_a) ang_r = lim_a;
    if (ang_r < -lim_a) ang_r = -lim_a;
    aerr = b_herr_q[15] ? 16'(-b_herr_q) : b_herr_q;
    rch = 1'b0; use_l = 1'b0; use_a = 1'b0;
    case (opcode_e'(b_w_q.opcode))
      OP_ROTATE: begin rch = aerr <= 16'(cfg_q.tol_heading); use_a = !rch; end
      OP_MOVE:   begin rch = b_dist_q <= 25'(cfg_q.tol_distance); use_l = !rch; end
      OP_DRIVE:  begin
        rch = b_dist_q <= 25'(cfg_q.tol_distance); use_l = !rch; use_a = !rch;
      end
      default: ;
    endcase
    if (b_w_q.obstacle) begin use_l = 1'b0; use_a = 1'b0; end
    c_d.linear_cmd    = use_l ? lin_r[23:0] : '0;
    c_d.angular_cmd   = use_a ? ang_r[15:0] : '0;
    c_d.reached       = rch;
    c_d.halted        = b_w_q.obstacle;
    c_d.distance_left = b_dist_q[24] ? 24'hFFFFFF : b_dist_q[23:0];
    c_d.heading_error = b_herr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) t_vld_q[i] <= 1'b0;
    end else if (adv) begin
      t_vld_q[0] <= g_vld;
      t_vld_q[1] <= t_vld_q[0];
      t_vld_q[2] <= t_vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_w_q    <= g_w;
      a_dist_q <= g_dist;
      a_herr_q <= (hr > 20'(ErrMax)) ? 16'(ErrMax)
                : (hr < -20'(ErrMax)) ? -16'(ErrMax) : hr[15:0];
      b_w_q    <= a_w_q;
      b_dist_q <= a_dist_q;
      b_herr_q <= a_herr_q;
      b_lin_q  <= 41'(cfg_q.gain_linear * a_dist_q);
      b_ang_q  <= 33'($signed({1'b0, cfg_q.gain_angular}) * a_herr_q);
      c_q      <= c_d;
    end
  end

  assign out_s.valid = t_vld_q[2];
  assign out_s.data  = c_q;
endmodule
